// ===== rtl/mcpid_pkg.sv =====
// shared types and constants for the multi-channel pid motor drive
// used by the output queue and the top level; no dependencies

package mcpid_pkg;

   localparam int NUM_CHANNELS_DEF   = 4;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   localparam int CHAN_W  = 2;
   localparam int SPEED_W = 16;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 15;
   localparam int DUTY_W  = 15;
   localparam int DIR_W   = 2;
   localparam int CSR_W   = 2;

   // results waiting for the consumer, must cover the three pipeline stages
   localparam int OUT_FIFO_DEPTH = 8;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd2560;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd768;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd256;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd999;

   typedef enum logic [DIR_W-1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_PROP_GAIN   = 2'd0,
      CSR_INTEG_GAIN  = 2'd1,
      CSR_DERIV_GAIN  = 2'd2,
      CSR_DRIVE_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DUTY_W-1:0] duty;
      dir_type           direction;
   } rsp_item_type;

endpackage

// ===== rtl/mcpid_out_fifo.sv =====
// result queue between the pid pipeline and the response channel
// depends on mcpid_pkg for the result item type

module mcpid_out_fifo #(
   parameter int DEPTH = mcpid_pkg::OUT_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  mcpid_pkg::rsp_item_type    push_item,
   input  logic                       pop_ready,
   output logic                       pop_valid,
   output mcpid_pkg::rsp_item_type    pop_item,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import mcpid_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/multi_channel_pid_motor_drive_top.sv =====
// multi-channel discrete pid speed controller, top level
// depends on mcpid_pkg and mcpid_out_fifo

// One control tick per req beat: the tick's channel rides in req_tuser, the
// setpoint and measured speed in req_tdata. The block forms the error, the
// P, I and D terms with unsigned fixed-point gains (GAIN_FRAC_BITS fraction
// bits), clamps the integral and then the sum to +-drive_limit, truncates
// toward zero and returns one rsp beat per tick as duty plus direction, in
// tick order. A new tick is taken every cycle while req_tready is high; the
// figure is set by the per-channel integral read-modify-write through a
// synchronous memory with a write-through bypass. A tick passes stages 1,
// 2 and 3 and then the result queue, and up to eight results queue behind
// a stalled consumer before req_tready drops. Ticks for a channel at or beyond
// NUM_CHANNELS return duty 0, stop, and leave all state alone. Per-channel
// state reads as zero after reset with no clearing pass. csr writes take
// effect at once and belong in idle periods.

module multi_channel_pid_motor_drive_top #(
   parameter int NUM_CHANNELS   = mcpid_pkg::NUM_CHANNELS_DEF,
   parameter int GAIN_FRAC_BITS = mcpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: target_speed [15:0], measured_speed [31:16]
   input  logic [31:0] req_tdata,
   // req_tuser: channel [1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: duty [14:0], direction [16:15], zero fill [23:17]
   output logic [23:0] rsp_tdata,
   // rsp_tuser: out_channel [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mcpid_pkg::*;

   localparam int CH_AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ERR_W    = SPEED_W + 1;
   localparam int GAIN_S_W = GAIN_W + 1;
   localparam int PROD_W   = ERR_W + GAIN_S_W;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int DPROD_W  = DIFF_W + GAIN_S_W;
   localparam int INTEG_W  = LIMIT_W + GAIN_FRAC_BITS + 1;
   localparam int ISUM_W   = ((INTEG_W > PROD_W) ? INTEG_W : PROD_W) + 1;
   localparam int PD_W     = DPROD_W + 1;
   localparam int SUM_W    = ((INTEG_W > PD_W) ? INTEG_W : PD_W) + 1;
   localparam int CNT_W    = $clog2(OUT_FIFO_DEPTH + 1);
   localparam int OCC_W    = CNT_W + 1;

   // configuration
   logic [GAIN_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [LIMIT_W-1:0] drive_limit_ff;

   // pipeline
   logic                      req_fire;
   logic [CHAN_W-1:0]         req_ch;
   logic [CH_AW-1:0]          req_addr;
   logic                      req_ok;
   logic signed [SPEED_W-1:0] target_s, measured_s;
   logic signed [ERR_W-1:0]   err_in;

   logic                      s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [CHAN_W-1:0]         s1_ch_ff, s2_ch_ff, s3_ch_ff;
   logic                      s1_ok_ff, s2_ok_ff, s3_ok_ff;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic [CH_AW-1:0]          s1_addr, s2_addr;

   logic signed [GAIN_S_W-1:0] kp_s, ki_s, kd_s;
   logic signed [PROD_W-1:0]   p_prod, i_prod;
   logic signed [DIFF_W-1:0]   err_diff;
   logic signed [DPROD_W-1:0]  d_prod;

   logic signed [PROD_W-1:0]   s2_p_ff, s2_ie_ff;
   logic signed [DPROD_W-1:0]  s2_d_ff;

   logic signed [ISUM_W-1:0]   lim_isum, isum, isum_clamp;
   logic signed [INTEG_W-1:0]  integ_new;
   logic signed [PD_W-1:0]     pd_sum;

   logic signed [PD_W-1:0]     s3_pd_ff;
   logic signed [INTEG_W-1:0]  s3_integ_ff;

   logic signed [SUM_W-1:0]    lim_sum, total, total_clamp;
   logic [SUM_W-1:0]           total_abs, total_mag;
   rsp_item_type               push_item, rsp_item;

   // state memories
   logic signed [INTEG_W-1:0] integ_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]   integ_vld_ff;
   logic signed [INTEG_W-1:0] integ_rd_ff;
   logic                      integ_we;

   logic signed [ERR_W-1:0]   lerr_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]   lerr_vld_ff;
   logic signed [ERR_W-1:0]   lerr_rd_ff;
   logic                      lerr_we;

   logic [CNT_W-1:0]          fifo_count;
   logic [OCC_W-1:0]          occupancy;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         drive_limit_ff <= DRIVE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_data;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_data;
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_data;
            CSR_DRIVE_LIMIT: drive_limit_ff <= csr_data[LIMIT_W-1:0];
         endcase
      end
   end

   // admission: every beat in flight owns a queue slot
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_vld_ff) + OCC_W'(s2_vld_ff)
                    + OCC_W'(s3_vld_ff);
   assign req_tready = (occupancy < OCC_W'(OUT_FIFO_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   assign req_ch     = req_tuser;
   assign req_addr   = CH_AW'(req_ch);
   assign req_ok     = (32'(req_ch) < 32'(NUM_CHANNELS));
   assign target_s   = signed'(req_tdata[SPEED_W-1:0]);
   assign measured_s = signed'(req_tdata[2*SPEED_W-1:SPEED_W]);
   assign err_in     = ERR_W'(target_s) - ERR_W'(measured_s);

   // last error: read old value and write the new one on the same edge
   assign lerr_we = req_fire && req_ok;

   always_ff @(posedge clock) begin
      lerr_rd_ff <= lerr_vld_ff[req_addr] ? lerr_mem[req_addr] : '0;
      if (lerr_we) begin
         lerr_mem[req_addr] <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lerr_vld_ff <= '0;
      end else if (lerr_we) begin
         lerr_vld_ff[req_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage 1: the three products
   assign s1_addr  = CH_AW'(s1_ch_ff);
   assign kp_s     = signed'({1'b0, prop_gain_ff});
   assign ki_s     = signed'({1'b0, integ_gain_ff});
   assign kd_s     = signed'({1'b0, deriv_gain_ff});
   assign p_prod   = PROD_W'(kp_s) * PROD_W'(s1_err_ff);
   assign i_prod   = PROD_W'(ki_s) * PROD_W'(s1_err_ff);
   assign err_diff = DIFF_W'(s1_err_ff) - DIFF_W'(lerr_rd_ff);
   assign d_prod   = DPROD_W'(kd_s) * DPROD_W'(err_diff);

   always_ff @(posedge clock) begin
      s1_ch_ff  <= req_ch;
      s1_ok_ff  <= req_ok;
      s1_err_ff <= err_in;
      s2_ch_ff  <= s1_ch_ff;
      s2_ok_ff  <= s1_ok_ff;
      s2_p_ff   <= p_prod;
      s2_ie_ff  <= i_prod;
      s2_d_ff   <= d_prod;
      s3_ch_ff    <= s2_ch_ff;
      s3_ok_ff    <= s2_ok_ff;
      s3_pd_ff    <= pd_sum;
      s3_integ_ff <= integ_new;
   end

   // stage 2: integral update, written back at the end of the stage
   assign s2_addr  = CH_AW'(s2_ch_ff);
   assign lim_isum = ISUM_W'(signed'({1'b0, drive_limit_ff})) <<< GAIN_FRAC_BITS;
   assign isum     = ISUM_W'(integ_rd_ff) + ISUM_W'(s2_ie_ff);

   always_comb begin
      if (isum > lim_isum) begin
         isum_clamp = lim_isum;
      end else if (isum < -lim_isum) begin
         isum_clamp = -lim_isum;
      end else begin
         isum_clamp = isum;
      end
   end

   assign integ_new = INTEG_W'(isum_clamp);
   assign pd_sum    = PD_W'(s2_p_ff) + PD_W'(s2_d_ff);
   assign integ_we  = s2_vld_ff && s2_ok_ff;

   // read for the tick now in stage 1; a same-channel write on this edge bypasses
   always_ff @(posedge clock) begin
      if (integ_we && (s2_addr == s1_addr)) begin
         integ_rd_ff <= integ_new;
      end else if (integ_vld_ff[s1_addr]) begin
         integ_rd_ff <= integ_mem[s1_addr];
      end else begin
         integ_rd_ff <= '0;
      end
      if (integ_we) begin
         integ_mem[s2_addr] <= integ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_vld_ff <= '0;
      end else if (integ_we) begin
         integ_vld_ff[s2_addr] <= 1'b1;
      end
   end

   // stage 3: output clamp and sign-magnitude conversion
   assign lim_sum = SUM_W'(signed'({1'b0, drive_limit_ff})) <<< GAIN_FRAC_BITS;
   assign total   = SUM_W'(s3_pd_ff) + SUM_W'(s3_integ_ff);

   always_comb begin
      if (total > lim_sum) begin
         total_clamp = lim_sum;
      end else if (total < -lim_sum) begin
         total_clamp = -lim_sum;
      end else begin
         total_clamp = total;
      end
   end

   assign total_abs = total_clamp[SUM_W-1] ? unsigned'(-total_clamp)
                                           : unsigned'(total_clamp);
   assign total_mag = total_abs >> GAIN_FRAC_BITS;

   always_comb begin
      push_item.channel   = s3_ch_ff;
      push_item.duty      = '0;
      push_item.direction = DIR_STOP;
      if (s3_ok_ff && (total_mag[DUTY_W-1:0] != '0)) begin
         push_item.duty      = total_mag[DUTY_W-1:0];
         push_item.direction = total_clamp[SUM_W-1] ? DIR_REV : DIR_FWD;
      end
   end

   mcpid_out_fifo #(
      .DEPTH (OUT_FIFO_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s3_vld_ff),
      .push_item  (push_item),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_item   (rsp_item),
      .count      (fifo_count)
   );

   assign rsp_tuser = rsp_item.channel;
   assign rsp_tdata = {7'b0, rsp_item.direction, rsp_item.duty};

   // queue slots are never overcommitted
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(OUT_FIFO_DEPTH))
      else $error("result queue overcommitted");

   // stop exactly when the duty is zero
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_item.duty == '0) == (rsp_item.direction == DIR_STOP)))
      else $error("direction and duty disagree");

   // a stored integral never leaves the clamp window
   a_integ_clamp: assert property (@(posedge clock) disable iff (reset)
      integ_we |-> ((ISUM_W'(integ_new) <= lim_isum) && (ISUM_W'(integ_new) >= -lim_isum)))
      else $error("integral written outside the limit");

endmodule
